// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the transposition cipher RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define CTCI_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define CTCI_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("assertion failed");
`else
`define CTCI_ASSERT(lbl, clk, rst_n, prop)
`define CTCI_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- rtl/ctci_pkg.sv -----
// Package for the columnar transposition cipher unit: sizes, codes, payload
// and control structs, and the key letter ranking function. No dependencies.
package ctci_pkg;

	localparam int KEY_MAX      = 16;
	localparam int LETTER_SLOTS = 16;
	localparam int LEN_LIMIT    = (KEY_MAX < LETTER_SLOTS) ? KEY_MAX : LETTER_SLOTS;
	localparam int KEY_W        = $clog2(KEY_MAX);
	localparam int POS_W        = $clog2(LEN_LIMIT);
	localparam int LEN_W        = 5;

	localparam int ROWQ_DEPTH = 4;
	localparam int ROWQ_W     = $clog2(ROWQ_DEPTH);
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_W     = $clog2(OUTQ_DEPTH);
	localparam int RAM_DEPTH  = ROWQ_DEPTH * KEY_MAX;
	localparam int RAM_AW     = ROWQ_W + KEY_W;

	localparam int CFG_AW = 5;
	localparam int CFG_DW = 64;

	localparam logic [7:0] PAD_BYTE   = 8'h20;
	localparam logic [4:0] RANK_OTHER = 5'd26;

	typedef enum logic [1:0] {
		REG_KEY_LOW  = 2'd0,
		REG_KEY_HIGH = 2'd1,
		REG_KEY_LEN  = 2'd2,
		REG_MODE     = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		KIND_CHAR  = 1'b0,
		KIND_FLUSH = 1'b1
	} item_kind_t;

	typedef struct packed {
		item_kind_t  kind;
		logic [7:0]  character;
	} item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       row_last;
	} result_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             mode;
		logic             busy;
		logic             clear_row;
	} cfg_t;

	typedef logic [KEY_MAX-1:0][KEY_W-1:0] order_t;

	typedef struct packed {
		logic [LEN_W-1:0] fill;
	} row_desc_t;

	typedef struct packed {
		logic              en;
		logic [RAM_AW-1:0] addr;
		logic [7:0]        data;
	} ram_wr_t;

	typedef struct packed {
		logic              en;
		logic [RAM_AW-1:0] addr;
	} ram_rd_t;

	// Letters rank 0..25 regardless of case; anything else ranks after z.
	function automatic logic [4:0] letter_rank(input logic [7:0] b);
		logic [7:0] lb;
		logic [7:0] d;
		lb = b;
		if (b >= 8'h41 && b <= 8'h5A) begin
			lb = b + 8'h20;
		end
		d = lb - 8'h61;
		if (lb >= 8'h61 && lb <= 8'h7A) begin
			return d[4:0];
		end
		return RANK_OTHER;
	endfunction

endpackage

// ----- rtl/ctci_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ctci_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/ctci_cfg.sv -----
// Configuration registers and the column order builder, which ranks one key
// position per cycle after a key write. Depends on ctci_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ctci_cfg import ctci_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output cfg_t              cfg,
	output order_t            order,
	output order_t            inv
);

	logic [63:0]      key_lo_q;
	logic [63:0]      key_hi_q;
	logic [4:0]       key_len_q;
	logic             mode_q;
	logic             busy_q;
	logic [POS_W-1:0] bp_q;
	order_t           order_q;
	order_t           inv_q;

	logic                         wr;
	cfg_reg_t                     widx;
	logic                         build_start;
	logic [LEN_W-1:0]             eff_len;
	logic [LETTER_SLOTS-1:0][7:0] letters;
	logic [LEN_LIMIT-1:0][4:0]    ranks;
	logic [4:0]                   rp;
	logic [POS_W:0]               slot;
	logic                         bp_live;

	assign wr   = psel & penable & pwrite;
	assign widx = cfg_reg_t'(paddr[CFG_AW-1:3]);
	assign build_start = wr && (widx == REG_KEY_LOW || widx == REG_KEY_HIGH ||
		widx == REG_KEY_LEN);

	always_comb begin
		if (key_len_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (key_len_q > LEN_W'(LEN_LIMIT)) begin
			eff_len = LEN_W'(LEN_LIMIT);
		end else begin
			eff_len = key_len_q;
		end
	end

	assign letters = {key_hi_q, key_lo_q};

	always_comb begin
		for (int i = 0; i < LEN_LIMIT; i++) begin
			ranks[i] = letter_rank(letters[i]);
		end
	end

	// Slot of the current position: how many positions in use sort ahead of it.
	always_comb begin
		rp   = ranks[bp_q];
		slot = '0;
		for (int q = 0; q < LEN_LIMIT; q++) begin
			if (LEN_W'(q) < eff_len && (ranks[q] < rp ||
				(ranks[q] == rp && POS_W'(q) < bp_q))) begin
				slot = slot + (POS_W+1)'(1);
			end
		end
		bp_live = LEN_W'(bp_q) < eff_len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q  <= '0;
			key_hi_q  <= '0;
			key_len_q <= 5'd1;
			mode_q    <= 1'b0;
			busy_q    <= 1'b0;
			bp_q      <= '0;
			for (int i = 0; i < KEY_MAX; i++) begin
				order_q[i] <= KEY_W'(i);
				inv_q[i]   <= KEY_W'(i);
			end
		end else begin
			if (wr) begin
				case (widx)
					REG_KEY_LOW:  key_lo_q  <= pwdata;
					REG_KEY_HIGH: key_hi_q  <= pwdata;
					REG_KEY_LEN:  key_len_q <= pwdata[4:0];
					REG_MODE:     mode_q    <= pwdata[0];
					default: ;
				endcase
			end
			if (build_start) begin
				busy_q <= 1'b1;
				bp_q   <= '0;
			end else if (busy_q) begin
				if (bp_live) begin
					order_q[KEY_W'(slot)] <= KEY_W'(bp_q);
					inv_q[KEY_W'(bp_q)]   <= KEY_W'(slot);
				end
				bp_q <= bp_q + POS_W'(1);
				if (bp_q == POS_W'(LEN_LIMIT - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_comb begin
		case (widx)
			REG_KEY_LOW:  prdata = key_lo_q;
			REG_KEY_HIGH: prdata = key_hi_q;
			REG_KEY_LEN:  prdata = {{(CFG_DW-5){1'b0}}, key_len_q};
			REG_MODE:     prdata = {{(CFG_DW-1){1'b0}}, mode_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg.len       = eff_len;
	assign cfg.mode      = mode_q;
	assign cfg.busy      = busy_q;
	assign cfg.clear_row = wr && (widx == REG_KEY_LEN);
	assign order         = order_q;
	assign inv           = inv_q;

	`CTCI_ASSERT(a_build_starts, clk, arst_n, build_start |=> busy_q)
	`CTCI_NEVER(a_order_inv_match, clk, arst_n, !busy_q && inv_q[order_q[0]] != '0)
	`CTCI_NEVER(a_order_head_range, clk, arst_n, !busy_q && LEN_W'(order_q[0]) >= eff_len)

endmodule

// ----- rtl/ctci_front.sv -----
// Front end: accepts characters and flushes, writes them into the row bank
// at the queue's write slot and hands finished rows on. Depends on ctci_pkg.
`include "assert_macros.svh"
module ctci_front import ctci_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  item_t             item,
	input  cfg_t              cfg,
	input  logic              rq_full,
	input  logic [ROWQ_W-1:0] rq_wptr,
	output ram_wr_t           wr,
	output logic              rq_push,
	output row_desc_t         rq_desc
);

	logic [LEN_W-1:0] fill_q;
	logic [LEN_W-1:0] fill_inc;
	logic             acc;
	logic             is_char;
	logic             row_done;

	assign acc      = push & ~rq_full;
	assign is_char  = item.kind == KIND_CHAR;
	assign fill_inc = fill_q + LEN_W'(1);
	assign row_done = fill_inc >= cfg.len;

	assign wr.en   = acc & is_char;
	assign wr.addr = {rq_wptr, KEY_W'(fill_q)};
	assign wr.data = item.character;

	// A flush of a partial row records how many entries are real; the rest
	// read back as padding.
	assign rq_push      = acc & (is_char ? row_done : (fill_q != '0));
	assign rq_desc.fill = is_char ? cfg.len : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cfg.clear_row) begin
			fill_q <= '0;
		end else if (acc) begin
			if (!is_char || row_done) begin
				fill_q <= '0;
			end else begin
				fill_q <= fill_inc;
			end
		end
	end

	`CTCI_NEVER(a_fill_below_len, clk, arst_n, fill_q >= cfg.len)
	`CTCI_NEVER(a_write_in_row, clk, arst_n, wr.en && rq_push && rq_desc.fill != fill_inc)

endmodule

// ----- rtl/ctci_rowq.sv -----
// Queue of finished row requests between the front and back ends; the slot
// index doubles as the row bank number. Depends on ctci_pkg.
`include "assert_macros.svh"
module ctci_rowq import ctci_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  row_desc_t         desc,
	input  logic              pop,
	output logic              full,
	output logic              empty,
	output logic [ROWQ_W-1:0] wptr,
	output logic [ROWQ_W-1:0] rptr,
	output row_desc_t         head
);

	row_desc_t         slot_q [ROWQ_DEPTH];
	logic [ROWQ_W-1:0] wp_q;
	logic [ROWQ_W-1:0] rp_q;
	logic [ROWQ_W:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + ROWQ_W'(1);
			end
			if (pop) begin
				rp_q <= rp_q + ROWQ_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (ROWQ_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (ROWQ_W+1)'(1);
			end
		end
	end

	assign full  = cnt_q == (ROWQ_W+1)'(ROWQ_DEPTH);
	assign empty = cnt_q == '0;
	assign wptr  = wp_q;
	assign rptr  = rp_q;
	assign head  = slot_q[rp_q];

	`CTCI_NEVER(a_push_full, clk, arst_n, push && full)
	`CTCI_NEVER(a_pop_empty, clk, arst_n, pop && empty)

endmodule

// ----- rtl/ctci_back.sv -----
// Back end: walks the head row in permuted column order, reads the row bank,
// substitutes padding and queues results. Depends on ctci_pkg.
`include "assert_macros.svh"
module ctci_back import ctci_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  order_t            order,
	input  order_t            inv,
	input  logic              rq_empty,
	input  logic [ROWQ_W-1:0] rq_rptr,
	input  row_desc_t         rq_head,
	input  logic [7:0]        rdata,
	input  logic              pop,
	output logic              rq_pop,
	output ram_rd_t           rd,
	output logic              empty,
	output result_t           result
);

	logic [KEY_W-1:0] k_q;
	logic             valid_s2;
	logic             pad_s2;
	logic             last_s2;

	result_t          oq_q [OUTQ_DEPTH];
	logic [OUTQ_W-1:0] owp_q;
	logic [OUTQ_W-1:0] orp_q;
	logic [OUTQ_W:0]   ocnt_q;

	logic [OUTQ_W+1:0] pending;
	logic              issue;
	logic [KEY_W-1:0]  src;
	logic              pad;
	logic [LEN_W-1:0]  k_inc;
	logic              last;
	logic              oq_pop;
	result_t           oq_in;

	// Results in flight count against free output slots.
	assign pending = (OUTQ_W+2)'(ocnt_q) + (OUTQ_W+2)'(valid_s2);
	assign issue   = ~rq_empty & ~cfg.busy & (pending < (OUTQ_W+2)'(OUTQ_DEPTH));
	assign src     = cfg.mode ? inv[k_q] : order[k_q];
	assign pad     = LEN_W'(src) >= rq_head.fill;
	assign k_inc   = LEN_W'(k_q) + LEN_W'(1);
	assign last    = k_inc == cfg.len;
	assign rq_pop  = issue & last;

	assign rd.en   = issue;
	assign rd.addr = {rq_rptr, src};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= issue;
			if (issue) begin
				k_q <= last ? '0 : KEY_W'(k_inc);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			pad_s2  <= pad;
			last_s2 <= last;
		end
	end

	assign oq_in.out_char = pad_s2 ? PAD_BYTE : rdata;
	assign oq_in.row_last = last_s2;
	assign oq_pop         = pop & ~empty;

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			oq_q[owp_q] <= oq_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= '0;
			orp_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (valid_s2) begin
				owp_q <= owp_q + OUTQ_W'(1);
			end
			if (oq_pop) begin
				orp_q <= orp_q + OUTQ_W'(1);
			end
			if (valid_s2 && !oq_pop) begin
				ocnt_q <= ocnt_q + (OUTQ_W+1)'(1);
			end else if (oq_pop && !valid_s2) begin
				ocnt_q <= ocnt_q - (OUTQ_W+1)'(1);
			end
		end
	end

	assign empty  = ocnt_q == '0;
	assign result = oq_q[orp_q];

	`CTCI_NEVER(a_oq_overflow, clk, arst_n, valid_s2 && !oq_pop && ocnt_q == (OUTQ_W+1)'(OUTQ_DEPTH))
	`CTCI_ASSERT(a_row_wraps, clk, arst_n, issue && last |=> k_q == '0)

endmodule

// ----- rtl/columnar_transposition_cipher_unit.sv -----
// Columnar transposition cipher unit. Takes one request per cycle while not
// full; finished rows leave through the registered output queue, one result
// per cycle while it has room, and up to 4 rows are held in the row banks. A
// key or key length write starts a column ranking pass; rows wait for it
// before they are emitted. Reset clears all control state and sets the column
// order to identity; row bank contents are not cleared.
module columnar_transposition_cipher_unit import ctci_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  item_t             item,
	output logic              empty,
	input  logic              pop,
	output result_t           result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready
);

	cfg_t              cfg;
	order_t            order;
	order_t            inv;
	ram_wr_t           ram_wr;
	ram_rd_t           ram_rd;
	logic [7:0]        ram_rdata;
	logic              rq_push;
	row_desc_t         rq_desc;
	logic              rq_pop;
	logic              rq_full;
	logic              rq_empty;
	logic [ROWQ_W-1:0] rq_wptr;
	logic [ROWQ_W-1:0] rq_rptr;
	row_desc_t         rq_head;

	assign pready = 1'b1;
	assign full   = rq_full;

	ctci_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg),
		.order   (order),
		.inv     (inv)
	);

	ctci_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.cfg     (cfg),
		.rq_full (rq_full),
		.rq_wptr (rq_wptr),
		.wr      (ram_wr),
		.rq_push (rq_push),
		.rq_desc (rq_desc)
	);

	ctci_rowq u_rowq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.desc   (rq_desc),
		.pop    (rq_pop),
		.full   (rq_full),
		.empty  (rq_empty),
		.wptr   (rq_wptr),
		.rptr   (rq_rptr),
		.head   (rq_head)
	);

	ctci_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_row_ram (
		.clk   (clk),
		.we    (ram_wr.en),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.re    (ram_rd.en),
		.raddr (ram_rd.addr),
		.rdata (ram_rdata)
	);

	ctci_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.order    (order),
		.inv      (inv),
		.rq_empty (rq_empty),
		.rq_rptr  (rq_rptr),
		.rq_head  (rq_head),
		.rdata    (ram_rdata),
		.pop      (pop),
		.rq_pop   (rq_pop),
		.rd       (ram_rd),
		.empty    (empty),
		.result   (result)
	);

endmodule
